// File: rtl/vector_interpolation_unit_assert.svh
// Assertion macros shared by the checker files of the vector interpolation unit.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef VECTOR_INTERPOLATION_UNIT_ASSERT_SVH
`define VECTOR_INTERPOLATION_UNIT_ASSERT_SVH

// The expression holds at every sampled edge.
`define VIU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The consequent holds at every sampled edge at which the antecedent holds.
`define VIU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/viu_pkg.sv
// Package of the vector interpolation unit: widths, rounding constants,
// the command encoding and the structs passed between pipeline sections.
// No dependencies.
package viu_pkg;

  localparam int FB   = 16;          // fraction bits of t
  localparam int TW   = FB + 1;      // width of t, which reaches 1.0
  localparam int PT_W = 32;          // width of a point component
  localparam int CW   = PT_W + 5;    // width of a doubled blend coefficient
  localparam int PW   = CW + TW + 1; // width of coefficient times a power of t
  localparam int AW   = PW + 2;      // accumulator width
  localparam int RW   = AW - FB - 1; // width of the rounded sum before clipping
  localparam int SQ_W = 2 * TW;      // width of a product of two t values

  localparam logic [TW-1:0]   ONE      = TW'(1) << FB;
  localparam logic [SQ_W:0]   SQ_HALF  = (SQ_W + 1)'(1) << (FB - 1);
  localparam logic [AW-1:0]   ACC_HALF = AW'(1) << FB;

  typedef enum logic [2:0] {
    CMD_LERP        = 3'd0,
    CMD_EASE_IN     = 3'd1,
    CMD_EASE_OUT    = 3'd2,
    CMD_EASE_IN_OUT = 3'd3,
    CMD_HERMITE     = 3'd4,
    CMD_CATMULL_ROM = 3'd5
  } cmd_t;

  // Sum is k0*ONE + k1*t + k2*t2 + k3*t3, always divided by 2*ONE at the end.
  typedef struct packed {
    logic signed [CW-1:0] k0;
    logic signed [CW-1:0] k1;
    logic signed [CW-1:0] k2;
    logic signed [CW-1:0] k3;
  } coef_t;

  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] k0;
    logic signed [PW-1:0] p1;
    logic signed [PW-1:0] p2;
    logic signed [PW-1:0] p3;
  } prod_t;

endpackage

// File: rtl/viu_coef.sv
// Command decoder of the vector interpolation unit: clamps t, picks the value
// to square and forms the blend coefficients of the selected mode.
// Depends on viu_pkg.
module viu_coef (
  input  logic [2:0]                       command,
  input  logic [viu_pkg::TW-1:0]           fraction,
  input  logic signed [viu_pkg::PT_W-1:0]  point_a,
  input  logic signed [viu_pkg::PT_W-1:0]  point_b,
  input  logic signed [viu_pkg::PT_W-1:0]  point_c,
  input  logic signed [viu_pkg::PT_W-1:0]  point_d,
  output logic [viu_pkg::TW-1:0]           t_o,
  output logic [viu_pkg::TW-1:0]           sq_in_o,
  output viu_pkg::coef_t                   coef_o
);

  localparam int EXT = viu_pkg::CW - viu_pkg::PT_W;

  logic [viu_pkg::TW-1:0]      t;
  logic [viu_pkg::TW:0]        x;
  logic [viu_pkg::TW:0]        x_hi;
  logic                        first_half;
  logic signed [viu_pkg::CW-1:0] ea, eb, ec, ed, dba;

  always_comb begin
    t          = (fraction > viu_pkg::ONE) ? viu_pkg::ONE : fraction;
    x          = {t, 1'b0};
    x_hi       = x - {1'b0, viu_pkg::ONE};
    first_half = (x <= {1'b0, viu_pkg::ONE});
  end

  assign ea  = {{EXT{point_a[viu_pkg::PT_W-1]}}, point_a};
  assign eb  = {{EXT{point_b[viu_pkg::PT_W-1]}}, point_b};
  assign ec  = {{EXT{point_c[viu_pkg::PT_W-1]}}, point_c};
  assign ed  = {{EXT{point_d[viu_pkg::PT_W-1]}}, point_d};
  assign dba = eb - ea;
  assign t_o = t;

  // Modes that divide by ONE get doubled coefficients so that every mode
  // rounds the same way after a division by 2*ONE.
  always_comb begin
    coef_o  = '0;
    sq_in_o = t;
    unique case (viu_pkg::cmd_t'(command))
      viu_pkg::CMD_LERP: begin
        coef_o.k0 = ea <<< 1;
        coef_o.k1 = dba <<< 1;
      end
      viu_pkg::CMD_EASE_IN: begin
        coef_o.k0 = ea <<< 1;
        coef_o.k2 = dba <<< 1;
      end
      viu_pkg::CMD_EASE_OUT: begin
        coef_o.k0 = ea <<< 1;
        coef_o.k1 = dba <<< 2;
        coef_o.k2 = -(dba <<< 1);
      end
      viu_pkg::CMD_EASE_IN_OUT: begin
        // The squared term comes from 2t in the first half and 2t-1 after it.
        coef_o.k0 = first_half ? (ea <<< 1) : (ea + eb);
        coef_o.k2 = dba;
        sq_in_o   = first_half ? x[viu_pkg::TW-1:0] : x_hi[viu_pkg::TW-1:0];
      end
      viu_pkg::CMD_HERMITE: begin
        coef_o.k0 = ea <<< 1;
        coef_o.k1 = ec <<< 1;
        coef_o.k2 = ((dba <<< 1) + dba - (ec <<< 1) - ed) <<< 1;
        coef_o.k3 = (ec + ed - (dba <<< 1)) <<< 1;
      end
      viu_pkg::CMD_CATMULL_ROM: begin
        coef_o.k0 = eb <<< 1;
        coef_o.k1 = ec - ea;
        coef_o.k2 = (ea <<< 1) - ((eb <<< 2) + eb) + (ec <<< 2) - ed;
        coef_o.k3 = ed - ea + (((eb - ec) <<< 1) + (eb - ec));
      end
      default: begin
        // Unused commands blend nothing, which rounds to a plain zero.
        coef_o = '0;
      end
    endcase
  end

endmodule

// File: rtl/viu_product.sv
// Multiplier section of the vector interpolation unit: three register stages
// that form t squared, t cubed and the products of the coefficients with them.
// Depends on viu_pkg.
module viu_product (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      valid_i,
  input  logic [viu_pkg::TW-1:0]    t_i,
  input  logic [viu_pkg::TW-1:0]    sq_in_i,
  input  viu_pkg::coef_t            coef_i,
  output viu_pkg::prod_t            prod_o
);

  // Stage 1: square.
  logic                            v1_r;
  logic [viu_pkg::TW-1:0]          t1_r;
  logic [viu_pkg::SQ_W-1:0]        sq1_r;
  viu_pkg::coef_t                  coef1_r;

  // Stage 2: t2 rounded, cube product, linear term.
  logic                            v2_r;
  logic [viu_pkg::TW-1:0]          t2_r;
  logic [viu_pkg::SQ_W-1:0]        cube2_r;
  logic signed [viu_pkg::PW-1:0]   p1_2_r;
  logic signed [viu_pkg::CW-1:0]   k0_2_r, k2_2_r, k3_2_r;

  // Stage 3: square and cube terms.
  logic                            v3_r;
  logic signed [viu_pkg::PW-1:0]   p1_3_r, p2_3_r, p3_3_r;
  logic signed [viu_pkg::CW-1:0]   k0_3_r;

  logic [viu_pkg::SQ_W:0]          sq_rnd;
  logic [viu_pkg::SQ_W:0]          cube_rnd;
  logic [viu_pkg::TW-1:0]          t2_nxt;
  logic [viu_pkg::TW-1:0]          t3_nxt;

  assign sq_rnd   = {1'b0, sq1_r} + viu_pkg::SQ_HALF;
  assign t2_nxt   = sq_rnd[viu_pkg::FB+viu_pkg::TW-1:viu_pkg::FB];
  assign cube_rnd = {1'b0, cube2_r} + viu_pkg::SQ_HALF;
  assign t3_nxt   = cube_rnd[viu_pkg::FB+viu_pkg::TW-1:viu_pkg::FB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_r    <= t_i;
    sq1_r   <= sq_in_i * sq_in_i;
    coef1_r <= coef_i;

    t2_r    <= t2_nxt;
    cube2_r <= t2_nxt * t1_r;
    p1_2_r  <= coef1_r.k1 * $signed({1'b0, t1_r});
    k0_2_r  <= coef1_r.k0;
    k2_2_r  <= coef1_r.k2;
    k3_2_r  <= coef1_r.k3;

    p1_3_r  <= p1_2_r;
    p2_3_r  <= k2_2_r * $signed({1'b0, t2_r});
    p3_3_r  <= k3_2_r * $signed({1'b0, t3_nxt});
    k0_3_r  <= k0_2_r;
  end

  assign prod_o.valid = v3_r;
  assign prod_o.k0    = k0_3_r;
  assign prod_o.p1    = p1_3_r;
  assign prod_o.p2    = p2_3_r;
  assign prod_o.p3    = p3_3_r;

endmodule

// File: rtl/viu_accum.sv
// Summing section of the vector interpolation unit: adds the four terms over
// two register stages, rounds half up, clips to 32 bits and drives the result.
// Depends on viu_pkg.
module viu_accum (
  input  logic                            clk,
  input  logic                            rst_n,
  input  viu_pkg::prod_t                  prod_i,
  output logic                            out_valid,
  output logic signed [viu_pkg::PT_W-1:0] out_value,
  output logic                            out_saturated
);

  localparam int K0_EXT = viu_pkg::AW - viu_pkg::CW - viu_pkg::FB;
  localparam int P_EXT  = viu_pkg::AW - viu_pkg::PW;

  logic                           v4_r;
  logic [viu_pkg::AW-1:0]         sa_r, sb_r;
  logic                           out_valid_r;
  logic [viu_pkg::PT_W-1:0]       out_value_r;
  logic                           out_saturated_r;

  logic [viu_pkg::AW-1:0]         k0_ext, p1_ext, p2_ext, p3_ext;
  logic [viu_pkg::AW-1:0]         acc;
  logic [viu_pkg::RW-1:0]         rounded;
  logic [viu_pkg::RW-viu_pkg::PT_W:0] top;
  logic                           clip;
  logic [viu_pkg::PT_W-1:0]       value_nxt;

  assign k0_ext = {{K0_EXT{prod_i.k0[viu_pkg::CW-1]}}, prod_i.k0, {viu_pkg::FB{1'b0}}};
  assign p1_ext = {{P_EXT{prod_i.p1[viu_pkg::PW-1]}}, prod_i.p1};
  assign p2_ext = {{P_EXT{prod_i.p2[viu_pkg::PW-1]}}, prod_i.p2};
  assign p3_ext = {{P_EXT{prod_i.p3[viu_pkg::PW-1]}}, prod_i.p3};

  // Floor of (sum + ONE) / (2*ONE) is the half-up rounding of sum / (2*ONE).
  assign acc     = sa_r + sb_r + viu_pkg::ACC_HALF;
  assign rounded = acc[viu_pkg::AW-1:viu_pkg::FB+1];
  assign top     = rounded[viu_pkg::RW-1:viu_pkg::PT_W-1];
  assign clip    = !((&top) || !(|top));

  always_comb begin
    value_nxt = rounded[viu_pkg::PT_W-1:0];
    if (clip) begin
      value_nxt = rounded[viu_pkg::RW-1] ? {1'b1, {(viu_pkg::PT_W-1){1'b0}}}
                                         : {1'b0, {(viu_pkg::PT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v4_r        <= prod_i.valid;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    sa_r            <= k0_ext + p1_ext;
    sb_r            <= p2_ext + p3_ext;
    out_value_r     <= value_nxt;
    out_saturated_r <= clip;
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_saturated_r;

endmodule

// File: rtl/vector_interpolation_unit.sv
// Vector interpolation unit, top level: one axis of lerp, ease or spline per word.
// Five register stages: three multiplier stages in series (t squared, t cubed,
// coefficient product) and two summing stages lie between the accepting edge and
// the out_valid strobe. Throughput is one word per cycle; busy is always low.
// Synchronous reset clears the valid bits, so words in flight are dropped.
// Depends on viu_pkg, viu_coef, viu_product and viu_accum.
module vector_interpolation_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      in_command,
  input  logic [viu_pkg::TW-1:0]          in_fraction,
  input  logic signed [viu_pkg::PT_W-1:0] in_point_a,
  input  logic signed [viu_pkg::PT_W-1:0] in_point_b,
  input  logic signed [viu_pkg::PT_W-1:0] in_point_c,
  input  logic signed [viu_pkg::PT_W-1:0] in_point_d,
  output logic                            out_valid,
  output logic signed [viu_pkg::PT_W-1:0] out_value,
  output logic                            out_saturated
);

  logic [viu_pkg::TW-1:0] t;
  logic [viu_pkg::TW-1:0] sq_in;
  viu_pkg::coef_t         coef;
  viu_pkg::prod_t         prod;
  logic                   accept;

  // The result side cannot stall, so the pipeline always takes a word.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  viu_coef u_coef (
    .command  (in_command),
    .fraction (in_fraction),
    .point_a  (in_point_a),
    .point_b  (in_point_b),
    .point_c  (in_point_c),
    .point_d  (in_point_d),
    .t_o      (t),
    .sq_in_o  (sq_in),
    .coef_o   (coef)
  );

  viu_product u_product (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (accept),
    .t_i     (t),
    .sq_in_i (sq_in),
    .coef_i  (coef),
    .prod_o  (prod)
  );

  viu_accum u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .prod_i        (prod),
    .out_valid     (out_valid),
    .out_value     (out_value),
    .out_saturated (out_saturated)
  );

endmodule

// File: rtl/viu_checker.sv
// Port-level checker of the vector interpolation unit, bound to the top level.
// Depends on viu_pkg and vector_interpolation_unit_assert.svh.
`include "vector_interpolation_unit_assert.svh"

module viu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [2:0]         in_command,
  input logic [16:0]        in_fraction,
  input logic signed [31:0] in_point_a,
  input logic signed [31:0] in_point_b,
  input logic signed [31:0] in_point_c,
  input logic signed [31:0] in_point_d,
  input logic               out_valid,
  input logic signed [31:0] out_value,
  input logic               out_saturated
);

  logic       acc_w;
  logic [4:0] acc_sr;
  logic [4:0] rst_sr;
  logic [4:0] unused_sr;
  logic [4:0] lerp0_sr;

  assign acc_w = start && !busy;

  // Five-bit histories, oldest in bit 4.
  always_ff @(posedge clk) begin
    acc_sr    <= {acc_sr[3:0], acc_w};
    rst_sr    <= {rst_sr[3:0], rst_n};
    unused_sr <= {unused_sr[3:0], acc_w && (in_command > viu_pkg::CMD_CATMULL_ROM)};
    lerp0_sr  <= {lerp0_sr[3:0],
                  acc_w && (in_command == viu_pkg::CMD_LERP) && (in_fraction == 17'd0)};
  end

  `VIU_ASSERT(a_never_busy, !busy, "busy rose although results are never held off")
  `VIU_ASSERT(a_latency, out_valid == (acc_sr[4] && (&rst_sr)), "result strobe off its slot")
  `VIU_ASSERT_IMPL(a_unused_zero, out_valid && unused_sr[4],
                   out_value == 0 && !out_saturated, "unused command gave a nonzero word")
  `VIU_ASSERT_IMPL(a_sat_rail, out_valid && out_saturated,
                   out_value[30:0] == {31{~out_value[31]}}, "clip flag without a rail value")
  `VIU_ASSERT_IMPL(a_lerp_start, out_valid && lerp0_sr[4],
                   out_value == $past(in_point_a, 5) && !out_saturated,
                   "lerp at t zero is not the start point")

endmodule

bind vector_interpolation_unit viu_checker u_viu_checker (.*);
